### rtl/core/fcwp_pkg.sv
// ----------------------------------------------------------------------------
// fcwp_pkg
// Shared constants, types and the unlock sequence table for the flash
// command and write protection block.
// ----------------------------------------------------------------------------
`default_nettype none

package fcwp_pkg;

   localparam int FLASH_BYTES  = 524288;
   localparam int ADDR_W       = $clog2(FLASH_BYTES);
   localparam int SECTOR_BYTES = 256;
   localparam int SECTOR_W     = $clog2(SECTOR_BYTES);
   localparam int MATCH_BITS   = 13;
   localparam int REQ_ADDR_W   = 19;
   localparam int DATA_W       = 8;
   localparam int STEP_W       = 4;

   localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'h10;
   localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h20;
   localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h30;
   localparam logic [DATA_W-1:0] CMD_READ_ID      = 8'h90;
   localparam logic [DATA_W-1:0] CONFIRM_SECTOR   = 8'hD0;
   localparam logic [DATA_W-1:0] CONFIRM_CHIP     = 8'h30;
   localparam logic [DATA_W-1:0] NOP_RESET        = 8'hFF;
   localparam logic [DATA_W-1:0] NOP_ZERO         = 8'h00;
   localparam logic [DATA_W-1:0] NOP_STATUS       = 8'hC3;
   localparam logic [DATA_W-1:0] ERASED_BYTE      = 8'hFF;
   localparam logic [DATA_W-1:0] CLEARED_BYTE     = 8'h00;

   localparam logic [STEP_W-1:0] UNLOCK_PHASE_STEP = 4'd0;
   localparam logic [STEP_W-1:0] LOCK_PHASE_STEP   = 4'd8;
   localparam logic [STEP_W-1:0] UNLOCK_DONE_STEP  = 4'd7;
   localparam logic [STEP_W-1:0] LOCK_DONE_STEP    = 4'd15;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DONE    = 2'd1,
      ST_LOCKED  = 2'd2,
      ST_IGNORED = 2'd3
   } rsp_status_type;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_ERASE = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic read_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic erase_req;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic [MATCH_BITS-1:0] seq_addr(input logic [STEP_W-1:0] step);
      logic [MATCH_BITS-1:0] a;
      unique case (step)
         4'd0, 4'd8:  a = 13'h1823;
         4'd1, 4'd9:  a = 13'h1820;
         4'd2, 4'd10: a = 13'h1822;
         4'd3, 4'd11: a = 13'h0418;
         4'd4, 4'd12: a = 13'h041B;
         4'd5, 4'd13: a = 13'h0419;
         4'd6:        a = 13'h041A;
         4'd14:       a = 13'h040A;
         default:     a = 13'h0000;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

### rtl/core/flash_command_and_write_protect_top.sv
// ----------------------------------------------------------------------------
// flash_command_and_write_protect_top
// Byte-wide flash array with software data protection and a two-write
// command interpreter (program, sector erase, chip erase).
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_kind, req_address, req_write_data
//   rsp      out        rsp_valid/rsp_ready  rsp_read_data, rsp_status, rsp_unlocked
//
// A write result is loaded at accept; a read result comes from the registered
// array read in S_READ. Sector erase holds req_ready low while it sweeps its
// 256 bytes, chip erase while it sweeps all FLASH_BYTES, one array byte per
// cycle through the write port. After reset a clearing pass writes zero to
// all FLASH_BYTES entries with req_ready low.
// A result waits in the output register; the next item is taken as soon as
// that register is free or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_command_and_write_protect_top import fcwp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire logic [REQ_ADDR_W-1:0] req_address,
   input  wire logic [DATA_W-1:0]     req_write_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [DATA_W-1:0]     rsp_read_data,
   output logic      [1:0]            rsp_status,
   output logic                       rsp_unlocked
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fcwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   fcwp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .rsp_unlocked   (rsp_unlocked),
      .status         (status)
   );

endmodule

`default_nettype wire

### rtl/core/fcwp_ram.sv
// ----------------------------------------------------------------------------
// fcwp_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcwp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/fcwp_ctrl.sv
// ----------------------------------------------------------------------------
// fcwp_ctrl
// Control state machine: clearing pass, item accept, read wait, erase sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module fcwp_ctrl import fcwp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   input  wire dp_status_type status,
   output logic               req_ready,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_ready     = (state_ff == S_IDLE) && !status.rsp_busy;
      cmd.accept    = req_ready && req_valid;
      cmd.sweep     = (state_ff == S_CLEAR) || (state_ff == S_ERASE);
      cmd.read_done = (state_ff == S_READ);
      state_in      = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.accept) begin
               if (!req_kind) begin
                  state_in = S_READ;
               end else if (status.erase_req) begin
                  state_in = S_ERASE;
               end
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_ERASE: begin
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/fcwp_dp.sv
// ----------------------------------------------------------------------------
// fcwp_dp
// Datapath: sequence matcher, command registers, sweep counter, flash array
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcwp_dp import fcwp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   input  wire logic                  req_kind,
   input  wire logic [REQ_ADDR_W-1:0] req_address,
   input  wire logic [DATA_W-1:0]     req_write_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic      [DATA_W-1:0]     rsp_read_data,
   output logic      [1:0]            rsp_status,
   output logic                       rsp_unlocked,
   output dp_status_type              status
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              we_ff, we_in;
   logic              pend_ff, pend_in;
   logic [DATA_W-1:0] pcmd_ff, pcmd_in;

   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_end_ff, sweep_end_in;
   logic [DATA_W-1:0] sweep_data_ff, sweep_data_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_data_ff, rsp_read_data_in;
   rsp_status_type    rsp_status_ff, rsp_status_in;
   logic              rsp_unlocked_ff, rsp_unlocked_in;

   logic [ADDR_W-1:0] idx;
   logic [STEP_W-1:0] step_next;
   rsp_status_type    wr_status;
   logic              prog_hit, sec_hit, chip_hit;
   logic              load_write;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic [DATA_W-1:0] ram_rd_data;

   assign idx       = req_address[ADDR_W-1:0];
   assign step_next = step_ff + STEP_W'(1);

   always_comb begin
      wr_status = ST_OK;
      prog_hit  = 1'b0;
      sec_hit   = 1'b0;
      chip_hit  = 1'b0;
      if (pend_ff) begin
         unique case (pcmd_ff)
            CMD_PROGRAM: begin
               prog_hit  = we_ff;
               wr_status = we_ff ? ST_DONE : ST_LOCKED;
            end
            CMD_SECTOR_ERASE: begin
               if (req_write_data != CONFIRM_SECTOR) begin
                  wr_status = ST_IGNORED;
               end else begin
                  sec_hit   = we_ff;
                  wr_status = we_ff ? ST_DONE : ST_LOCKED;
               end
            end
            CMD_CHIP_ERASE: begin
               if (req_write_data != CONFIRM_CHIP) begin
                  wr_status = ST_IGNORED;
               end else begin
                  chip_hit  = we_ff;
                  wr_status = we_ff ? ST_DONE : ST_LOCKED;
               end
            end
            CMD_READ_ID: begin
               wr_status = ST_OK;
            end
            default: begin
               wr_status = ST_IGNORED;
            end
         endcase
      end
   end

   assign status.erase_req  = req_kind && (sec_hit || chip_hit);
   assign status.sweep_last = (sweep_addr_ff == sweep_end_ff);
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign load_write        = cmd.accept && req_kind;

   // advance or rewind the matcher, track the command cycle
   always_comb begin
      step_in = step_ff;
      we_in   = we_ff;
      pend_in = pend_ff;
      pcmd_in = pcmd_ff;
      if (cmd.accept) begin
         if (!req_kind) begin
            if (req_address[MATCH_BITS-1:0] == seq_addr(step_ff)) begin
               if (step_next == UNLOCK_DONE_STEP) begin
                  step_in = LOCK_PHASE_STEP;
                  we_in   = 1'b1;
               end else if (step_next == LOCK_DONE_STEP) begin
                  step_in = UNLOCK_PHASE_STEP;
                  we_in   = 1'b0;
               end else begin
                  step_in = step_next;
               end
            end else begin
               step_in = step_ff & LOCK_PHASE_STEP;
            end
         end else begin
            step_in = step_ff & LOCK_PHASE_STEP;
            if (!pend_ff) begin
               if (!(req_write_data inside {NOP_RESET, NOP_ZERO, NOP_STATUS})) begin
                  pend_in = 1'b1;
                  pcmd_in = req_write_data;
               end
            end else begin
               pend_in = 1'b0;
               pcmd_in = '0;
            end
         end
      end
   end

   always_comb begin
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      sweep_data_in = sweep_data_ff;
      if (cmd.accept && status.erase_req) begin
         sweep_data_in = ERASED_BYTE;
         if (chip_hit) begin
            sweep_addr_in = '0;
            sweep_end_in  = '1;
         end else begin
            sweep_addr_in = {idx[ADDR_W-1:SECTOR_W], SECTOR_W'(0)};
            sweep_end_in  = {idx[ADDR_W-1:SECTOR_W], {SECTOR_W{1'b1}}};
         end
      end else if (cmd.sweep) begin
         sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      ram_wr_en   = cmd.sweep || (load_write && prog_hit);
      ram_wr_addr = cmd.sweep ? sweep_addr_ff : idx;
      ram_wr_data = cmd.sweep ? sweep_data_ff : req_write_data;
   end

   fcwp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FLASH_BYTES)
   ) u_flash (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (idx),
      .rd_data (ram_rd_data)
   );

   // load the result register; a write result is ready at accept
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_unlocked_in  = rsp_unlocked_ff;
      if (load_write) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = '0;
         rsp_status_in    = wr_status;
         rsp_unlocked_in  = we_ff;
      end else if (cmd.read_done) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = ram_rd_data;
         rsp_status_in    = ST_OK;
         rsp_unlocked_in  = we_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= UNLOCK_PHASE_STEP;
         we_ff         <= 1'b0;
         pend_ff       <= 1'b0;
         pcmd_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= '1;
         sweep_data_ff <= CLEARED_BYTE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         we_ff         <= we_in;
         pend_ff       <= pend_in;
         pcmd_ff       <= pcmd_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
         sweep_data_ff <= sweep_data_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_unlocked_ff  <= rsp_unlocked_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_unlocked  = rsp_unlocked_ff;

endmodule

`default_nettype wire

### rtl/core/fcwp_checker.sv
// ----------------------------------------------------------------------------
// fcwp_checker
// Port-level checks on the result channel and protection reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module fcwp_checker import fcwp_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_read_data,
   input wire logic [1:0]        rsp_status,
   input wire logic              rsp_unlocked
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_status) && $stable(rsp_unlocked))
      else $error("result changed while stalled");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while result register is full");

   a_done_unlocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DONE |-> rsp_unlocked)
      else $error("program or erase reported while locked");

   a_refused_locked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LOCKED |-> !rsp_unlocked)
      else $error("refusal reported while unlocked");

   a_write_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_data == '0)
      else $error("write result carries read data");

endmodule

bind flash_command_and_write_protect_top fcwp_checker u_fcwp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data),
   .rsp_status    (rsp_status),
   .rsp_unlocked  (rsp_unlocked)
);

`default_nettype wire

### tb/tb_flash_command_and_write_protect_top.sv
// ----------------------------------------------------------------------------
// tb_flash_command_and_write_protect_top
// Self-checking bench for the protected flash block. A short directed run
// covers a locked refusal, unlocking, program, both erases, a no-op code
// and a bad confirm. It is followed by random unlock/lock walks, command pairs
// and reads with random idles on both channels. A scoreboard class predicts
// every response and checks it in order.
// ----------------------------------------------------------------------------
module tb_flash_command_and_write_protect_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fcwp_pkg::*;

   localparam int ITEM_COUNT   = 2000;
   localparam int STALL_LIMIT  = 4 * FLASH_BYTES;
   localparam int IDLE_PCT     = 38;
   localparam int REPORT_MAX   = 10;
   localparam int DRAIN_CYCLES = 16;
   localparam int CALM_FIRST   = 900;
   localparam int CALM_LAST    = 1200;

   typedef enum logic {
      ACC_READ  = 1'b0,
      ACC_WRITE = 1'b1
   } access_kind_type;

   localparam logic [MATCH_BITS-1:0] UNLOCK_WALK [16] = '{
      13'h1823, 13'h1820, 13'h1822, 13'h0418, 13'h041B, 13'h0419, 13'h041A, 13'h0000,
      13'h1823, 13'h1820, 13'h1822, 13'h0418, 13'h041B, 13'h0419, 13'h040A, 13'h0000
   };

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      rsp_status_type    status;
      logic              unlocked;
   } flash_rsp_type;

   class flash_scoreboard;
      logic [DATA_W-1:0] byte_map [int unsigned];
      logic [DATA_W-1:0] fill_byte = CLEARED_BYTE;
      logic [STEP_W-1:0] walk_pos  = UNLOCK_PHASE_STEP;
      logic              writable  = 1'b0;
      logic              cmd_open  = 1'b0;
      logic [DATA_W-1:0] open_cmd  = CLEARED_BYTE;
      flash_rsp_type     due_responses [$];
      int                mismatches = 0;

      function void note_access(access_kind_type kind, logic [REQ_ADDR_W-1:0] address,
                                logic [DATA_W-1:0] data);
         int unsigned       idx;
         int unsigned       base;
         logic [STEP_W-1:0] nxt;
         flash_rsp_type     rsp;
         idx = address % FLASH_BYTES;
         rsp.read_data = CLEARED_BYTE;
         rsp.status    = ST_OK;
         if (kind == ACC_READ) begin
            if (address[MATCH_BITS-1:0] == UNLOCK_WALK[walk_pos]) begin
               nxt = walk_pos + 1'b1;
               if (nxt == UNLOCK_DONE_STEP) begin
                  nxt      = LOCK_PHASE_STEP;
                  writable = 1'b1;
               end else if (nxt == LOCK_DONE_STEP) begin
                  nxt      = UNLOCK_PHASE_STEP;
                  writable = 1'b0;
               end
               walk_pos = nxt;
            end else begin
               walk_pos = walk_pos & LOCK_PHASE_STEP;
            end
            rsp.read_data = byte_map.exists(idx) ? byte_map[idx] : fill_byte;
         end else begin
            walk_pos = walk_pos & LOCK_PHASE_STEP;
            if (!cmd_open) begin
               if (data != NOP_RESET && data != NOP_ZERO && data != NOP_STATUS) begin
                  open_cmd = data;
                  cmd_open = 1'b1;
               end
            end else begin
               case (open_cmd)
                  CMD_PROGRAM: begin
                     if (!writable) begin
                        rsp.status = ST_LOCKED;
                     end else begin
                        byte_map[idx] = data;
                        rsp.status    = ST_DONE;
                     end
                  end
                  CMD_SECTOR_ERASE: begin
                     if (data != CONFIRM_SECTOR) begin
                        rsp.status = ST_IGNORED;
                     end else if (!writable) begin
                        rsp.status = ST_LOCKED;
                     end else begin
                        base = idx & ~(SECTOR_BYTES - 1);
                        for (int i = 0; i < SECTOR_BYTES; i++)
                           if (base + i < FLASH_BYTES)
                              byte_map[base + i] = ERASED_BYTE;
                        rsp.status = ST_DONE;
                     end
                  end
                  CMD_CHIP_ERASE: begin
                     if (data != CONFIRM_CHIP) begin
                        rsp.status = ST_IGNORED;
                     end else if (!writable) begin
                        rsp.status = ST_LOCKED;
                     end else begin
                        byte_map.delete();
                        fill_byte  = ERASED_BYTE;
                        rsp.status = ST_DONE;
                     end
                  end
                  CMD_READ_ID: rsp.status = ST_OK;
                  default:     rsp.status = ST_IGNORED;
               endcase
               cmd_open = 1'b0;
               open_cmd = CLEARED_BYTE;
            end
         end
         rsp.unlocked = writable;
         due_responses.push_back(rsp);
      endfunction

      function void check_response(logic [DATA_W-1:0] read_data, logic [1:0] status,
                                   logic unlocked);
         flash_rsp_type want;
         if (due_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected response read_data=%02h status=%0d unlocked=%0b",
                        $time, read_data, status, unlocked);
            return;
         end
         want = due_responses.pop_front();
         if (read_data !== want.read_data || status !== want.status ||
             unlocked !== want.unlocked) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: mismatch expected %02h/%0d/%0b actual %02h/%0d/%0b",
                        $time, want.read_data, want.status, want.unlocked,
                        read_data, status, unlocked);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_kind;
   logic [REQ_ADDR_W-1:0] req_address;
   logic [DATA_W-1:0]     req_write_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [DATA_W-1:0]     rsp_read_data;
   logic [1:0]            rsp_status;
   logic                  rsp_unlocked;

   int              items_sent  = 0;
   int              idle_cycles = 0;
   bit              calm        = 1'b0;
   bit              allow_chip  = 1'b0;
   flash_scoreboard sb          = new();

   flash_command_and_write_protect_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .rsp_unlocked   (rsp_unlocked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_read_data, rsp_status, rsp_unlocked);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_access(input access_kind_type kind,
                              input logic [REQ_ADDR_W-1:0] address,
                              input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] payload;
      payload = data;
      // keep full chip erases out of the random part
      if (kind == ACC_WRITE && !allow_chip && sb.writable && sb.cmd_open &&
          sb.open_cmd == CMD_CHIP_ERASE && payload == CONFIRM_CHIP)
         payload = payload ^ 8'h01;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_address    <= address;
      req_write_data <= payload;
      do @(posedge clock); while (!req_ready);
      sb.note_access(kind, address, payload);
      items_sent++;
      calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
   endtask

   function automatic logic [REQ_ADDR_W-1:0] pool_addr();
      logic [REQ_ADDR_W-1:0] base;
      case ($urandom_range(0, 3))
         0:       base = '0;
         1:       base = REQ_ADDR_W'(FLASH_BYTES - SECTOR_BYTES);
         2:       base = 19'h12300;
         default: base = 19'h45600;
      endcase
      return base + REQ_ADDR_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, SECTOR_BYTES - 1));
   endfunction

   // walk the current phase to its end, or drop out early on a stray item
   task automatic walk_phase(input int break_pct);
      logic                             phase;
      logic [REQ_ADDR_W-MATCH_BITS-1:0] high_bits;
      phase = sb.writable;
      while (sb.writable == phase) begin
         if ($urandom_range(0, 99) < break_pct) begin
            send_access(access_kind_type'($urandom_range(0, 1)), REQ_ADDR_W'($urandom),
                        DATA_W'($urandom));
            return;
         end
         high_bits = (REQ_ADDR_W-MATCH_BITS)'($urandom);
         send_access(ACC_READ, {high_bits, UNLOCK_WALK[sb.walk_pos]}, DATA_W'($urandom));
      end
   endtask

   task automatic run_command_pair();
      int                pick;
      logic [DATA_W-1:0] opcode;
      logic [DATA_W-1:0] second;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         opcode = CMD_PROGRAM;
      else if (pick < 65)
         opcode = CMD_SECTOR_ERASE;
      else if (pick < 73)
         opcode = CMD_CHIP_ERASE;
      else if (pick < 80)
         opcode = CMD_READ_ID;
      else if (pick < 88) begin
         case ($urandom_range(0, 2))
            0:       opcode = NOP_RESET;
            1:       opcode = NOP_ZERO;
            default: opcode = NOP_STATUS;
         endcase
      end else
         opcode = DATA_W'($urandom);
      send_access(ACC_WRITE, pool_addr(), opcode);
      case (opcode)
         CMD_SECTOR_ERASE:
            second = ($urandom_range(0, 9) < 8) ? CONFIRM_SECTOR : DATA_W'($urandom);
         CMD_CHIP_ERASE:
            second = ($urandom_range(0, 9) < 5) ? CONFIRM_CHIP : DATA_W'($urandom);
         default:
            second = DATA_W'($urandom);
      endcase
      send_access(ACC_WRITE, pool_addr(), second);
   endtask

   initial begin
      int pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = ACC_READ;
      req_address    = '0;
      req_write_data = '0;
      rsp_ready      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_access(ACC_READ, REQ_ADDR_W'(FLASH_BYTES - 1), 8'h00);
      send_access(ACC_WRITE, '0, CMD_CHIP_ERASE);
      send_access(ACC_WRITE, '0, CONFIRM_CHIP);
      walk_phase(0);
      send_access(ACC_WRITE, '0, CMD_PROGRAM);
      send_access(ACC_WRITE, REQ_ADDR_W'(FLASH_BYTES - 1), 8'h5A);
      send_access(ACC_READ, REQ_ADDR_W'(FLASH_BYTES - 1), 8'hFF);
      send_access(ACC_WRITE, '0, CMD_SECTOR_ERASE);
      send_access(ACC_WRITE, REQ_ADDR_W'(FLASH_BYTES - 128), CONFIRM_SECTOR);
      send_access(ACC_WRITE, '0, CMD_SECTOR_ERASE);
      send_access(ACC_WRITE, '0, 8'h11);
      send_access(ACC_WRITE, 19'h00100, NOP_RESET);
      send_access(ACC_WRITE, '0, CMD_READ_ID);
      send_access(ACC_WRITE, '0, 8'hAB);
      send_access(ACC_WRITE, '0, 8'h55);
      send_access(ACC_WRITE, '0, NOP_ZERO);
      allow_chip = 1'b1;
      send_access(ACC_WRITE, 19'h7FFFF, CMD_CHIP_ERASE);
      send_access(ACC_WRITE, 19'h2AAAA, CONFIRM_CHIP);
      allow_chip = 1'b0;
      send_access(ACC_READ, '0, 8'h00);

      while (items_sent < ITEM_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            walk_phase(4);
         else if (pick < 65)
            run_command_pair();
         else if (pick < 85)
            repeat ($urandom_range(1, 3))
               send_access(ACC_READ, pool_addr(), DATA_W'($urandom));
         else
            send_access(access_kind_type'($urandom_range(0, 1)), REQ_ADDR_W'($urandom),
                        DATA_W'($urandom));
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_responses.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
